>>> src/modular_inverse_ext_euclid_defines.svh
// ---------------------------------------------------------------------------
// Modular inverse assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MIE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mie_pkg.sv
// ---------------------------------------------------------------------------
// Modular inverse package
// Default sizes, reset modulus and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package mie_pkg;

    // Default operand and modulus width.
    localparam int WIDTH = 32;

    // Modulus after reset, cut to the configured width at the top level.
    localparam logic [63:0] MOD_RESET = 64'd998244353;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take a new operand and the modulus
        logic div_init;  // start a quotient: divisor and coefficient copies
        logic norm;      // shift divisor copies left by one
        logic sub;       // conditional subtract, then shift copies right
        logic swap;      // rotate remainders and coefficients
        logic fix1;      // lift a negative coefficient into range
        logic fix2;      // drop a coefficient that reached the modulus
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic m_zero;    // configured modulus is zero
        logic r1_zero;   // Euclid loop has finished
        logic can_norm;  // divisor doubled still fits under the remainder
        logic cnt_zero;  // last quotient bit is being processed
    } t_status;

endpackage

>>> src/mie_ctrl.sv
// ---------------------------------------------------------------------------
// Modular inverse controller
// Sequences load, Euclid steps, coefficient fixup and result hand-off.
// ---------------------------------------------------------------------------
module mie_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_out_free,
    input  mie_pkg::t_status i_status,
    output logic             o_stall,
    output logic             o_deliver,
    output mie_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_NORM,
        S_SUB,
        S_SWAP,
        S_FIX1,
        S_FIX2,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    // Next state and datapath commands.
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_deliver = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.m_zero ? S_DONE : S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.r1_zero) begin
                    n_state = S_FIX1;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_NORM;
                end
            end
            S_NORM: begin
                if (i_status.can_norm) begin
                    o_cmd.norm = 1'b1;
                end else begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                if (i_status.cnt_zero) begin
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                o_cmd.swap = 1'b1;
                n_state    = S_TEST;
            end
            S_FIX1: begin
                o_cmd.fix1 = 1'b1;
                n_state    = S_FIX2;
            end
            S_FIX2: begin
                o_cmd.fix2 = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_deliver = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_busy  = (n_state != S_IDLE);
    assign o_stall = r_busy;

    // State and the registered stall toward the sender.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

endmodule

>>> src/mie_dp.sv
// ---------------------------------------------------------------------------
// Modular inverse datapath
// Remainders and Bezout coefficients with a shift-subtract quotient unit.
// ---------------------------------------------------------------------------
module mie_dp #(
    parameter int WIDTH = mie_pkg::WIDTH
) (
    input  logic             i_clk,
    input  mie_pkg::t_cmd    i_cmd,
    input  logic [WIDTH-1:0] i_operand,
    input  logic [WIDTH-1:0] i_modulus,
    output mie_pkg::t_status o_status,
    output logic [WIDTH-1:0] o_inverse,
    output logic             o_exists
);

    // Coefficients never exceed twice the modulus in magnitude.
    localparam int SW = WIDTH + 2;
    localparam int CW = $clog2(WIDTH);

    logic        [WIDTH-1:0] r_r0;
    logic        [WIDTH-1:0] r_r1;
    logic signed [SW-1:0]    r_s0;
    logic signed [SW-1:0]    r_s1;
    logic        [WIDTH:0]   r_d;
    logic signed [SW-1:0]    r_t;
    logic        [CW-1:0]    r_cnt;
    logic signed [SW-1:0]    r_res;
    logic                    r_ok;

    logic        [WIDTH:0]   w_d2;
    logic                    w_ge;
    logic signed [SW-1:0]    w_m_ext;

    assign w_d2    = {r_d[WIDTH-1:0], 1'b0};
    assign w_ge    = (r_d <= {1'b0, r_r0});
    assign w_m_ext = {2'b00, i_modulus};

    // Status toward the controller.
    assign o_status.m_zero   = (i_modulus == '0);
    assign o_status.r1_zero  = (r_r1 == '0);
    assign o_status.can_norm = !r_d[WIDTH] && (w_d2 <= {1'b0, r_r0});
    assign o_status.cnt_zero = (r_cnt == '0);

    // A missing inverse always reads as zero.
    assign o_inverse = r_ok ? r_res[WIDTH-1:0] : '0;
    assign o_exists  = r_ok;

    // One Euclid step is a quotient found one bit per cycle: the divisor is
    // first doubled up to the remainder, then subtracted back down. The
    // coefficient copy follows the divisor, so s0 - q*s1 needs no multiplier.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r0  <= i_operand;
            r_r1  <= i_modulus;
            r_s0  <= SW'(1);
            r_s1  <= '0;
            r_ok  <= 1'b0;
            r_res <= '0;
        end else if (i_cmd.div_init) begin
            r_d   <= {1'b0, r_r1};
            r_t   <= r_s1;
            r_cnt <= '0;
        end else if (i_cmd.norm) begin
            r_d   <= w_d2;
            r_t   <= r_t <<< 1;
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.sub) begin
            if (w_ge) begin
                r_r0 <= r_r0 - r_d[WIDTH-1:0];
                r_s0 <= r_s0 - r_t;
            end
            r_d <= r_d >> 1;
            r_t <= r_t >>> 1;
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end else if (i_cmd.swap) begin
            r_r0 <= r_r1;
            r_r1 <= r_r0;
            r_s0 <= r_s1;
            r_s1 <= r_s0;
        end else if (i_cmd.fix1) begin
            r_ok  <= (r_r0 == WIDTH'(1));
            r_res <= r_s0[SW-1] ? (r_s0 + w_m_ext) : r_s0;
        end else if (i_cmd.fix2) begin
            if (r_res >= w_m_ext) begin
                r_res <= r_res - w_m_ext;
            end
        end
    end

endmodule

>>> src/modular_inverse_ext_euclid.sv
// ---------------------------------------------------------------------------
// Modular inverse, extended Euclidean algorithm
// Returns the inverse of each operand modulo a configured modulus.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid, o_stall, i_operand. A word is taken on a rising
//   edge with i_valid high and o_stall low. One operand is worked at a time.
//   Output channel: o_valid, i_stall, o_inverse, o_exists. One result word
//   per operand; o_exists is low and o_inverse zero when no inverse exists.
//   The modulus is written through i_cfg_we / i_cfg_data while idle.
// Sequence:
//   Each operand runs Euclid steps, then a coefficient fixup; the first step
//   reduces the operand. The quotient loop of the datapath finds one bit
//   per cycle. A zero modulus skips the Euclid steps and the fixup.
// Reset and stall:
//   Synchronous reset empties the block and restores the modulus 998244353.
//   A finished word waits in the output register while i_stall is high; the
//   next operand is already taken and worked, and then waits for that slot.
// ---------------------------------------------------------------------------
`include "modular_inverse_ext_euclid_defines.svh"

module modular_inverse_ext_euclid #(
    parameter int WIDTH = mie_pkg::WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WIDTH-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_operand,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_inverse,
    output logic             o_exists
);

    mie_pkg::t_cmd    w_cmd;
    mie_pkg::t_status w_status;
    logic             w_deliver;
    logic             w_out_free;
    logic [WIDTH-1:0] w_inverse;
    logic             w_exists;

    logic [WIDTH-1:0] r_modulus;
    logic             r_o_valid;
    logic [WIDTH-1:0] r_o_inverse;
    logic             r_o_exists;

    assign w_out_free = !r_o_valid || !i_stall;

    // Modulus register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mie_pkg::MOD_RESET[WIDTH-1:0];
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    mie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_stall    (o_stall),
        .o_deliver  (w_deliver),
        .o_cmd      (w_cmd)
    );

    mie_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_operand (i_operand),
        .i_modulus (r_modulus),
        .o_status  (w_status),
        .o_inverse (w_inverse),
        .o_exists  (w_exists)
    );

    // Output register separating the datapath from the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_deliver) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_deliver) begin
            r_o_inverse <= w_inverse;
            r_o_exists  <= w_exists;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_inverse = r_o_inverse;
    assign o_exists  = r_o_exists;

    // An accepted operand keeps the input side closed on the next cycle.
    `MIE_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall,
                     "input still open after an operand was taken")
    // A word without an inverse carries zero.
    `MIE_ASSERT_SAME(a_zero_when_none, o_valid && !o_exists, o_inverse == '0,
                     "nonzero inverse reported with no inverse")
    // A reported inverse lies below the modulus.
    `MIE_ASSERT_SAME(a_inverse_in_range, o_valid && o_exists, o_inverse < r_modulus,
                     "inverse not below the modulus")

endmodule
